// ===== rtl/qcls_pkg.sv =====
`timescale 1ns / 1ps

package qcls_pkg;

    localparam logic [7:0] CH_ESCAPE = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_QUOTE  = 2'd1,
        ERR_ESCAPE = 2'd2
    } err_code_t;

    typedef struct packed {
        logic      escape_pending;
        logic      in_quote;
        logic      quote_is_single;
        logic      token_nonempty;
    } split_state_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       token_end;
        err_code_t  error_code;
        logic       string_done;
    } split_result_t;

    function automatic logic [7:0] unescape_byte(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            CH_N:    r = CH_LF;
            CH_T:    r = CH_TAB;
            default: r = b;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/quoted_command_line_splitter.sv =====
`timescale 1ns / 1ps

// Splits a byte stream into space-separated tokens, shell style. Each input
// transaction carries at most one string byte and an end-of-string flag; it
// produces at most one result transaction (a token byte after unescaping, a
// token-end mark, and on the last one string_done with an error code for an
// open quote or a dangling backslash). Bytes already sent are never retracted.
// One transaction is taken per clock while the output register is empty or
// m_ready is high: the decode is one combinational step on four state bits,
// and the result sits in one output register that is refilled in the same
// cycle it is drained: throughput is one byte per cycle while m_ready is high.
module quoted_command_line_splitter (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_in_byte,
    input  logic                  s_has_byte,
    input  logic                  s_end_of_string,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_byte,
    output logic                  m_byte_valid,
    output logic                  m_token_end,
    output qcls_pkg::err_code_t   m_error_code,
    output logic                  m_string_done
);
    import qcls_pkg::*;

    split_state_t  state_reg, state_next;
    split_result_t result_reg, result_next;
    logic          m_valid_reg, m_valid_next;
    logic          emit;
    logic          accept;
    logic          is_single;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next             = state_reg;
        result_next            = '0;
        result_next.error_code = ERR_NONE;
        is_single              = (s_in_byte == CH_SQUOTE);
        if (s_has_byte) begin
            if (state_reg.escape_pending) begin
                state_next.escape_pending = 1'b0;
                result_next.out_byte      = unescape_byte(s_in_byte);
                result_next.byte_valid    = 1'b1;
            end else if (s_in_byte == CH_ESCAPE) begin
                state_next.escape_pending = 1'b1;
            end else if (s_in_byte == CH_SPACE) begin
                if (state_reg.in_quote) begin
                    result_next.out_byte   = s_in_byte;
                    result_next.byte_valid = 1'b1;
                end else if (state_reg.token_nonempty) begin
                    result_next.token_end     = 1'b1;
                    state_next.token_nonempty = 1'b0;
                end
            end else if (s_in_byte inside {CH_DQUOTE, CH_SQUOTE}) begin
                if (!state_reg.in_quote) begin
                    state_next.in_quote        = 1'b1;
                    state_next.quote_is_single = is_single;
                end else if (state_reg.quote_is_single == is_single) begin
                    state_next.in_quote = 1'b0;
                end else begin
                    result_next.out_byte   = s_in_byte;
                    result_next.byte_valid = 1'b1;
                end
            end else begin
                result_next.out_byte   = s_in_byte;
                result_next.byte_valid = 1'b1;
            end
            if (result_next.byte_valid) begin
                state_next.token_nonempty = 1'b1;
            end
        end
        if (s_end_of_string) begin
            if (state_next.escape_pending) begin
                result_next.error_code = ERR_ESCAPE;
            end else if (state_next.in_quote) begin
                result_next.error_code = ERR_QUOTE;
            end
            if (state_next.token_nonempty) begin
                result_next.token_end = 1'b1;
            end
            result_next.string_done = 1'b1;
            state_next              = '0;
        end
        emit = result_next.byte_valid || result_next.token_end || result_next.string_done;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = emit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            result_reg <= result_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = result_reg.out_byte;
    assign m_byte_valid  = result_reg.byte_valid;
    assign m_token_end   = result_reg.token_end;
    assign m_error_code  = result_reg.error_code;
    assign m_string_done = result_reg.string_done;

    a_err_only_at_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error_code != ERR_NONE) |-> m_string_done)
        else $error("error code without string end");

    a_clear_after_eos: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_end_of_string) |=> (state_reg == '0))
        else $error("state not cleared after string end");

    a_escaped_byte_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_has_byte && state_reg.escape_pending) |=> (m_valid && m_byte_valid))
        else $error("escaped byte not emitted");

    a_idle_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_byte_valid) |-> (m_out_byte == 8'd0))
        else $error("out byte nonzero without byte valid");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import qcls_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SHOWN_MISMATCHES = 10;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       s_has_byte = 1'b0;
    logic       s_end_of_string = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_byte_valid;
    logic       m_token_end;
    err_code_t  m_error_code;
    logic       m_string_done;

    // splitter state as predicted
    logic esc_armed = 1'b0;
    logic quoting = 1'b0;
    logic quote_single = 1'b0;
    logic token_open = 1'b0;

    split_result_t expected_results[$];

    int idle_pct = 17;
    int cycle_count = 0;
    int failures = 0;
    int strings_sent = 0;
    int tokens_seen = 0;
    int quote_flags = 0;
    int escape_flags = 0;

    quoted_command_line_splitter i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .s_has_byte      (s_has_byte),
        .s_end_of_string (s_end_of_string),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_byte_valid    (m_byte_valid),
        .m_token_end     (m_token_end),
        .m_error_code    (m_error_code),
        .m_string_done   (m_string_done)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= idle_pct);
    end

    function automatic bit split_byte(input logic [7:0] b, input logic hb, input logic eos,
                                      output split_result_t r);
        logic       emit;
        logic       tend;
        logic [7:0] ob;
        err_code_t  err;
        emit = 1'b0;
        tend = 1'b0;
        ob = 8'h00;
        err = ERR_NONE;
        if (hb) begin
            if (esc_armed) begin
                esc_armed = 1'b0;
                emit = 1'b1;
                case (b)
                    CH_N:    ob = CH_LF;
                    CH_T:    ob = CH_TAB;
                    default: ob = b;
                endcase
            end else if (b == CH_ESCAPE) begin
                esc_armed = 1'b1;
            end else if (b == CH_SPACE) begin
                if (quoting) begin
                    emit = 1'b1;
                    ob = b;
                end else if (token_open) begin
                    tend = 1'b1;
                    token_open = 1'b0;
                end
            end else if (b == CH_SQUOTE || b == CH_DQUOTE) begin
                if (!quoting) begin
                    quoting = 1'b1;
                    quote_single = (b == CH_SQUOTE);
                end else if (quote_single == (b == CH_SQUOTE)) begin
                    quoting = 1'b0;
                end else begin
                    emit = 1'b1;
                    ob = b;
                end
            end else begin
                emit = 1'b1;
                ob = b;
            end
            if (emit) token_open = 1'b1;
        end
        if (eos) begin
            if (esc_armed) err = ERR_ESCAPE;
            else if (quoting) err = ERR_QUOTE;
            if (token_open) tend = 1'b1;
            esc_armed = 1'b0;
            quoting = 1'b0;
            quote_single = 1'b0;
            token_open = 1'b0;
        end
        r.out_byte = ob;
        r.byte_valid = emit;
        r.token_end = tend;
        r.error_code = err;
        r.string_done = eos;
        return emit || tend || eos;
    endfunction

    task automatic note_failure(input string msg);
        if (failures < SHOWN_MISMATCHES) $display("mismatch: %s", msg);
        failures++;
    endtask

    always @(posedge aclk) begin
        split_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                note_failure($sformatf(
                    "unexpected transaction byte=%02h bv=%0d te=%0d err=%0d sd=%0d",
                    m_out_byte, m_byte_valid, m_token_end, m_error_code, m_string_done));
            end else begin
                want = expected_results.pop_front();
                if (m_out_byte !== want.out_byte || m_byte_valid !== want.byte_valid ||
                    m_token_end !== want.token_end || m_error_code !== want.error_code ||
                    m_string_done !== want.string_done) begin
                    note_failure($sformatf(
                        {"exp byte=%02h bv=%0d te=%0d err=%0d sd=%0d, ",
                         "got byte=%02h bv=%0d te=%0d err=%0d sd=%0d"},
                        want.out_byte, want.byte_valid, want.token_end, want.error_code,
                        want.string_done, m_out_byte, m_byte_valid, m_token_end,
                        m_error_code, m_string_done));
                end
            end
            if (m_token_end === 1'b1) tokens_seen++;
            if (m_string_done === 1'b1 && m_error_code == ERR_QUOTE) quote_flags++;
            if (m_string_done === 1'b1 && m_error_code == ERR_ESCAPE) escape_flags++;
        end
    end

    task automatic send_item(input logic [7:0] b, input logic hb, input logic eos);
        int gap;
        split_result_t r;
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_byte <= b;
        s_has_byte <= hb;
        s_end_of_string <= eos;
        do @(posedge aclk); while (!s_ready);
        if (split_byte(b, hb, eos, r)) expected_results.insert(expected_results.size(), r);
        if (eos) strings_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic test_plain_tokens();
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(CH_SPACE, 1'b1, 1'b0);
        send_item(CH_SPACE, 1'b1, 1'b0);
        send_item(8'hAA, 1'b0, 1'b0);
    endtask

    task automatic test_escapes();
        send_item(CH_ESCAPE, 1'b1, 1'b0);
        send_item(CH_N, 1'b1, 1'b0);
        send_item(CH_ESCAPE, 1'b1, 1'b0);
        send_item(CH_T, 1'b1, 1'b0);
        send_item(CH_ESCAPE, 1'b1, 1'b0);
        send_item(CH_SPACE, 1'b1, 1'b0);
        send_item(CH_ESCAPE, 1'b1, 1'b0);
        send_item(CH_DQUOTE, 1'b1, 1'b0);
        send_item(CH_ESCAPE, 1'b1, 1'b0);
        send_item(CH_ESCAPE, 1'b1, 1'b1);
    endtask

    task automatic test_quotes();
        send_item(CH_SQUOTE, 1'b1, 1'b0);
        send_item(CH_DQUOTE, 1'b1, 1'b0);
        send_item(CH_SPACE, 1'b1, 1'b0);
        send_item(CH_SQUOTE, 1'b1, 1'b1);
        send_item(8'h55, 1'b0, 1'b1);
    endtask

    task automatic test_error_flags();
        send_item(CH_DQUOTE, 1'b1, 1'b0);
        send_item(CH_SQUOTE, 1'b1, 1'b0);
        send_item(CH_ESCAPE, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(CH_DQUOTE, 1'b1, 1'b0);
        send_item(8'h78, 1'b1, 1'b1);
    endtask

    function automatic logic [7:0] pick_plain();
        logic [7:0] b;
        do b = 8'($urandom_range(255));
        while (b == CH_SPACE || b == CH_ESCAPE || b == CH_SQUOTE || b == CH_DQUOTE);
        return b;
    endfunction

    function automatic logic [7:0] pick_noise();
        case ($urandom_range(7))
            0:       return CH_SPACE;
            1:       return CH_ESCAPE;
            2:       return CH_SQUOTE;
            3:       return CH_DQUOTE;
            4:       return $urandom_range(1) ? CH_N : CH_T;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic build_words(ref logic [7:0] str[$]);
        logic [7:0] q;
        int pieces;
        pieces = $urandom_range(8);
        repeat (pieces) begin
            case ($urandom_range(9))
                0, 1: repeat ($urandom_range(1, 3)) str.insert(str.size(), CH_SPACE);
                2: begin
                    str.insert(str.size(), CH_ESCAPE);
                    case ($urandom_range(4))
                        0:       str.insert(str.size(), CH_N);
                        1:       str.insert(str.size(), CH_T);
                        default: str.insert(str.size(), 8'($urandom_range(255)));
                    endcase
                end
                3, 4: begin
                    q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
                    str.insert(str.size(), q);
                    repeat ($urandom_range(5)) begin
                        case ($urandom_range(4))
                            0:       str.insert(str.size(), CH_SPACE);
                            1:       str.insert(str.size(),
                                                q == CH_SQUOTE ? CH_DQUOTE : CH_SQUOTE);
                            default: str.insert(str.size(), pick_plain());
                        endcase
                    end
                    str.insert(str.size(), q);
                end
                default: repeat ($urandom_range(1, 6)) str.insert(str.size(), pick_plain());
            endcase
        end
    endtask

    task automatic test_random_strings(input int n_items, input int pct);
        logic [7:0] str[$];
        int sent;
        int kind;
        bit eos_on_byte;
        idle_pct = pct;
        sent = 0;
        while (sent < n_items) begin
            str.delete();
            kind = $urandom_range(99);
            if (kind < 75) begin
                build_words(str);
            end else if (kind < 87) begin
                build_words(str);
                str.insert(str.size(), $urandom_range(1) ? CH_ESCAPE
                           : ($urandom_range(1) ? CH_SQUOTE : CH_DQUOTE));
            end else begin
                repeat ($urandom_range(12)) str.insert(str.size(), pick_noise());
            end
            eos_on_byte = (str.size() != 0) && $urandom_range(1);
            foreach (str[i]) begin
                if ($urandom_range(9) == 0)
                    send_item(8'($urandom_range(255)), 1'b0, 1'b0);
                send_item(str[i], 1'b1, eos_on_byte && i == str.size() - 1);
                sent++;
            end
            if (!eos_on_byte) begin
                send_item(8'($urandom_range(255)), 1'b0, 1'b1);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_plain_tokens();
        wait_drained();
        test_escapes();
        wait_drained();
        test_quotes();
        wait_drained();
        test_error_flags();
        wait_drained();
        test_random_strings(320, 17);
        test_random_strings(230, 0);
        wait_drained();
        test_random_strings(300, 17);
        wait_drained();
        idle_pct = 0;
        repeat (8) @(posedge aclk);
        if (expected_results.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", expected_results.size()));
        end
        $display("split %0d strings into %0d tokens; flagged %0d open quotes, %0d escapes",
                 strings_sent, tokens_seen, quote_flags, escape_flags);
        $display("%0d mismatches in %0d cycles", failures, cycle_count);
        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== quoted_command_line_splitter.f =====
rtl/qcls_pkg.sv
rtl/quoted_command_line_splitter.sv
tb/tb.sv
